/* rtl/core/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC-16 byte update for the frame checker.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam int          MAX_PAYLOAD_DEF = 32;
    localparam int          HDR_LEN         = 11;
    localparam int          MIN_LEN         = 13;
    localparam logic [5:0]  COUNT_MAX       = 6'd63;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam int          PADDR_W         = 3;

    // register select bit of paddr
    localparam logic REG_PREAMBLE = 1'b0;
    localparam logic REG_VERSION  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CRC   = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  msg_class;
        logic [7:0]  node_class;
        logic [15:0] source_node;
        logic [15:0] dest_node;
        logic [7:0]  frame_flags;
        logic [7:0]  seq_number;
        logic [5:0]  body_length;
        logic [15:0] received_crc;
    } t_desc;

    typedef struct packed {
        t_status     status;
        logic        is_payload;
        logic [7:0]  msg_class;
        logic [7:0]  node_class;
        logic [15:0] source_node;
        logic [15:0] dest_node;
        logic [7:0]  frame_flags;
        logic [7:0]  seq_number;
        logic [5:0]  body_length;
        logic [15:0] received_crc;
        logic [7:0]  payload_byte;
        logic        last_result;
    } t_result;

    // crc-16, msb first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/crcfr_front.sv */
// ----------------------------------------------------------------------------
// crcfr_front
// Takes frame bytes, runs the delayed crc, keeps the header and classifies
// each frame at its end into a descriptor for the result queue.
// ----------------------------------------------------------------------------
module crcfr_front
    import crcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int PAY_DEPTH   = MAX_PAYLOAD + 2,
    parameter int PAW         = $clog2(PAY_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_frame_end,
    input  logic [7:0]     i_exp_preamble,
    input  logic [7:0]     i_exp_version,
    output logic           o_push,
    output t_desc          o_desc,
    input  logic           i_q_full,
    input  logic           i_drain_done,
    output logic           o_wr_en,
    output logic [PAW-1:0] o_wr_addr,
    output logic [7:0]     o_wr_data
);

    logic [5:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_dly0, n_dly0;
    logic [7:0]  r_dly1, n_dly1;
    logic [7:0]  r_hdr [HDR_LEN];
    logic        r_lock, n_lock;

    logic        accept;
    logic        in_payload;
    logic [5:0]  pay_off;
    logic [15:0] fed_crc;
    logic [15:0] rcrc;
    logic [5:0]  len;
    logic [7:0]  plen;
    t_status     status;

    assign in_payload = (r_count >= 6'(HDR_LEN));
    assign o_in_stall = (r_lock && in_payload) || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign pay_off    = r_count - 6'(HDR_LEN);

    assign o_wr_en   = accept && in_payload && (7'(pay_off) < 7'(PAY_DEPTH));
    assign o_wr_addr = PAW'(pay_off);
    assign o_wr_data = i_rx_byte;

    // byte two places back enters the crc
    assign fed_crc = (r_count >= 6'd2) ? crc_feed(r_crc, r_dly0) : r_crc;
    assign rcrc    = {r_dly1, i_rx_byte};
    assign len     = (r_count < COUNT_MAX) ? r_count + 6'd1 : r_count;
    assign plen    = r_hdr[10];

    always_comb begin
        if (len < 6'(MIN_LEN)) begin
            status = ST_SHORT;
        end else if (r_hdr[0] != i_exp_preamble || r_hdr[1] != i_exp_version) begin
            status = ST_BAD_HDR;
        end else if (plen > 8'(MAX_PAYLOAD)
                     || {3'b000, len} != {1'b0, plen} + 9'(MIN_LEN)) begin
            status = ST_BAD_LEN;
        end else if (fed_crc != rcrc) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_desc.status       = status;
        o_desc.msg_class    = r_hdr[2];
        o_desc.node_class   = r_hdr[3];
        o_desc.source_node  = {r_hdr[4], r_hdr[5]};
        o_desc.dest_node    = {r_hdr[6], r_hdr[7]};
        o_desc.frame_flags  = r_hdr[8];
        o_desc.seq_number   = r_hdr[9];
        o_desc.body_length  = plen[5:0];
        o_desc.received_crc = rcrc;
    end

    assign o_push = accept && i_frame_end;

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_dly0  = r_dly0;
        n_dly1  = r_dly1;
        n_lock  = r_lock;
        if (i_drain_done) begin
            n_lock = 1'b0;
        end
        if (accept) begin
            if (i_frame_end) begin
                n_count = '0;
                n_crc   = CRC_INIT;
                n_dly0  = '0;
                n_dly1  = '0;
                // payload store stays owned by the drain until it finishes
                if (status == ST_OK && plen != 8'd0) begin
                    n_lock = 1'b1;
                end
            end else begin
                n_count = len;
                n_crc   = fed_crc;
                n_dly0  = r_dly1;
                n_dly1  = i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_dly0  <= '0;
            r_dly1  <= '0;
            r_lock  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_dly0  <= n_dly0;
            r_dly1  <= n_dly1;
            r_lock  <= n_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HDR_LEN; i++) begin
            if (accept && r_count == 6'(i)) begin
                r_hdr[i] <= i_rx_byte;
            end
        end
    end

endmodule

/* rtl/core/crcfr_queue.sv */
// ----------------------------------------------------------------------------
// crcfr_queue
// Two-entry descriptor queue between the byte front and the result drain.
// ----------------------------------------------------------------------------
module crcfr_queue
    import crcfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_head
);

    t_desc      r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_desc;
        end
    end

endmodule

/* rtl/core/crcfr_back.sv */
// ----------------------------------------------------------------------------
// crcfr_back
// Drains frame descriptors into results: the status word, then, for a good
// frame, one word per payload byte read from the payload memory.
// ----------------------------------------------------------------------------
module crcfr_back
    import crcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int PAY_DEPTH   = MAX_PAYLOAD + 2,
    parameter int PAW         = $clog2(PAY_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [PAW-1:0] i_wr_addr,
    input  logic [7:0]     i_wr_data,
    input  logic           i_q_empty,
    input  t_desc          i_head,
    output logic           o_pop,
    output logic           o_drain_done,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output t_result        o_result
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state         r_state, n_state;
    logic [PAW-1:0] r_idx, n_idx;
    logic [5:0]     r_plen, n_plen;
    logic           r_out_valid, n_out_valid;
    t_result        r_out, n_out;
    logic [7:0]     r_mem [PAY_DEPTH];
    logic [7:0]     r_rdata;
    logic           out_free;
    logic           last_pay;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign last_pay    = (7'(r_idx) + 7'd1 == 7'(r_plen));
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_plen       = r_plen;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        o_pop        = 1'b0;
        o_drain_done = 1'b0;
        if (out_free) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.status = i_head.status;
                    if (i_head.status == ST_OK) begin
                        n_out.msg_class    = i_head.msg_class;
                        n_out.node_class   = i_head.node_class;
                        n_out.source_node  = i_head.source_node;
                        n_out.dest_node    = i_head.dest_node;
                        n_out.frame_flags  = i_head.frame_flags;
                        n_out.seq_number   = i_head.seq_number;
                        n_out.body_length  = i_head.body_length;
                        n_out.received_crc = i_head.received_crc;
                        n_out.last_result  = (i_head.body_length == 6'd0);
                        if (i_head.body_length != 6'd0) begin
                            n_state = S_DRAIN;
                            n_idx   = '0;
                            n_plen  = i_head.body_length;
                        end
                    end else begin
                        n_out.last_result = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.status       = ST_OK;
                    n_out.is_payload   = 1'b1;
                    n_out.payload_byte = r_rdata;
                    n_out.last_result  = last_pay;
                    if (last_pay) begin
                        n_state      = S_IDLE;
                        o_drain_done = 1'b1;
                    end else begin
                        n_idx = r_idx + PAW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plen <= n_plen;
        r_out  <= n_out;
    end

    // read data always tracks the entry the drain index will point at
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[n_idx];
    end

endmodule

/* rtl/core/crc_frame_receiver_checker.sv */
// ----------------------------------------------------------------------------
// crc_frame_receiver_checker
// Frame deframer with CRC-16 (poly 0x1021, init 0xFFFF) and header checks.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on i_in_valid/o_in_stall with i_frame_end on the
// last byte. Results leave on o_out_valid/i_out_stall: one status word per
// frame and, for a good frame, one word per payload byte, last_result on the
// final one. expected preamble and version are written over the APB port
// (0x0 and 0x4) while the block is idle; the user keeps to this, the block
// does not enforce it. Throughput: one byte per cycle while o_in_stall is
// low. A frame's payload bytes wait while the previous good frame's payload
// is still being drained, since both share one payload memory. The two-entry
// descriptor queue holds finished frames. The status word goes via the queue
// and output register; payload words follow one per cycle if not stalled.
// Reset: synchronous, active low; clears the byte count, crc, queue and
// output valid. A receiver stall holds the output word and backs up into the
// queue, then into the byte input.
// ----------------------------------------------------------------------------
module crc_frame_receiver_checker
    import crcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_end,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic               o_is_payload,
    output logic [7:0]         o_msg_class,
    output logic [7:0]         o_node_class,
    output logic [15:0]        o_source_node,
    output logic [15:0]        o_dest_node,
    output logic [7:0]         o_frame_flags,
    output logic [7:0]         o_seq_number,
    output logic [5:0]         o_body_length,
    output logic [15:0]        o_received_crc,
    output logic [7:0]         o_payload_byte,
    output logic               o_last_result
);

    localparam int PAY_DEPTH = MAX_PAYLOAD + 2;
    localparam int PAW       = $clog2(PAY_DEPTH);

    logic [7:0]     r_exp_preamble;
    logic [7:0]     r_exp_version;
    logic           cfg_wr;
    logic           push, pop, q_full, q_empty, drain_done;
    t_desc          fr_desc, q_head;
    logic           wr_en;
    logic [PAW-1:0] wr_addr;
    logic [7:0]     wr_data;
    t_result        result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_VERSION) ? {24'h000000, r_exp_version}
                                              : {24'h000000, r_exp_preamble};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_preamble <= '0;
            r_exp_version  <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PREAMBLE) begin
                r_exp_preamble <= pwdata[7:0];
            end else begin
                r_exp_version <= pwdata[7:0];
            end
        end
    end

    crcfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .PAY_DEPTH   (PAY_DEPTH),
        .PAW         (PAW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .i_exp_preamble (r_exp_preamble),
        .i_exp_version  (r_exp_version),
        .o_push         (push),
        .o_desc         (fr_desc),
        .i_q_full       (q_full),
        .i_drain_done   (drain_done),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

    crcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (fr_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    crcfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .PAY_DEPTH   (PAY_DEPTH),
        .PAW         (PAW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_q_empty    (q_empty),
        .i_head       (q_head),
        .o_pop        (pop),
        .o_drain_done (drain_done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (result)
    );

    assign o_status       = result.status;
    assign o_is_payload   = result.is_payload;
    assign o_msg_class    = result.msg_class;
    assign o_node_class   = result.node_class;
    assign o_source_node  = result.source_node;
    assign o_dest_node    = result.dest_node;
    assign o_frame_flags  = result.frame_flags;
    assign o_seq_number   = result.seq_number;
    assign o_body_length  = result.body_length;
    assign o_received_crc = result.received_crc;
    assign o_payload_byte = result.payload_byte;
    assign o_last_result  = result.last_result;

endmodule
